/* sv/keyed_slot_sorter_macros.svh */
// ============================================================================
// Keyed slot sorter assertion macros
// Shared assertion forms for the sorter's checker.
// ============================================================================
`ifndef KEYED_SLOT_SORTER_MACROS_SVH
`define KEYED_SLOT_SORTER_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define KSS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keyed_slot_sorter check failed");

// Checks a property on every clock edge, reset included.
`define KSS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("keyed_slot_sorter reset check failed");

`endif

/* sv/kss_pkg.sv */
// ============================================================================
// Keyed slot sorter package
// Types, constants and the rank lookup shared by the sorter's modules.
// ============================================================================
`timescale 1ns / 1ps

package kss_pkg;

    localparam int ENTRIES_DEF = 32;

    localparam logic [1:0] MODE_BATTLE = 2'd0;
    localparam logic [1:0] MODE_RAISE  = 2'd1;
    localparam logic [1:0] MODE_BASIC  = 2'd2;

    localparam logic [2:0] CAT_MAX    = 3'd5;
    localparam logic [7:0] EMPTY_RANK = 8'd255;
    localparam logic [7:0] EMPTY_TYPE_RESET = 8'd255;

    localparam logic [0:0] REG_SORT_MODE  = 1'b0;
    localparam logic [0:0] REG_EMPTY_TYPE = 1'b1;

    localparam logic [5:0][7:0] RANK_BATTLE = {8'd4, 8'd5, 8'd2, 8'd3, 8'd1, 8'd0};
    localparam logic [5:0][7:0] RANK_RAISE  = {8'd1, 8'd4, 8'd5, 8'd0, 8'd3, 8'd2};
    localparam logic [5:0][7:0] RANK_BASIC  = {8'd4, 8'd5, 8'd3, 8'd0, 8'd2, 8'd1};

    typedef struct packed {
        logic [7:0] item_type;
        logic [2:0] item_category;
        logic [7:0] item_amount;
        logic [7:0] name_index;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_type;
        logic [7:0] out_amount;
        logic [7:0] out_name_index;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] rank;
        logic [7:0] name_index;
        logic [7:0] amount;
        logic [7:0] item_type;
    } entry_t;

    typedef struct packed {
        logic [1:0] sort_mode;
        logic [7:0] empty_type;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic emit;
        logic emit_last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic one_left;
    } status_t;

    // Category must already be known to be within the table.
    function automatic logic [7:0] rank_of(logic [1:0] mode, logic [2:0] cat);
        logic [7:0] rank;
        case (mode)
            MODE_BATTLE: rank = RANK_BATTLE[cat];
            MODE_RAISE:  rank = RANK_RAISE[cat];
            default:     rank = RANK_BASIC[cat];
        endcase
        return rank;
    endfunction

endpackage

/* sv/kss_ctrl.sv */
// ============================================================================
// Keyed slot sorter controller
// Accepts entries, starts the drain on the last entry and paces the results.
// ============================================================================
`timescale 1ns / 1ps

module kss_ctrl
    import kss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    in_last,
    input  status_t status,
    output logic    busy,
    output logic    out_valid,
    output cmd_t    cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy = (state_reg == ST_DRAIN);
    assign out_valid = out_valid_reg;

    assign cmd.load      = accept && !status.full;
    assign cmd.emit      = (state_reg == ST_DRAIN);
    assign cmd.emit_last = (state_reg == ST_DRAIN) && status.one_left;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.one_left)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= cmd.emit;
        end
    end

endmodule

/* sv/kss_dp.sv */
// ============================================================================
// Keyed slot sorter datapath
// Insertion chain that keeps loaded entries in key order and drains them.
// ============================================================================
`timescale 1ns / 1ps

module kss_dp
    import kss_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_item_t  in_item,
    input  cmd_t      cmd,
    output status_t   status,
    output out_item_t out_data
);

    entry_t               cell_reg [ENTRIES];
    entry_t               cell_next [ENTRIES];
    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [ENTRIES-1:0]   gt;
    entry_t               new_entry;
    logic [15:0]          new_key;
    out_item_t            out_reg;

    always_comb
    begin
        new_entry.item_type  = in_item.item_type;
        new_entry.amount     = in_item.item_amount;
        new_entry.name_index = in_item.name_index;
        if ((in_item.item_type == cfg.empty_type) || (in_item.item_category > CAT_MAX))
        begin
            new_entry.rank = EMPTY_RANK;
        end
        else
        begin
            new_entry.rank = rank_of(cfg.sort_mode, in_item.item_category);
        end
        new_key = {new_entry.rank, new_entry.item_type};
    end

    genvar i;
    generate
        for (i = 0; i < ENTRIES; i++)
        begin : g_cell
            assign gt[i] = !valid_reg[i]
                || ({cell_reg[i].rank, cell_reg[i].item_type} > new_key);

            always_comb
            begin
                cell_next[i]  = cell_reg[i];
                valid_next[i] = valid_reg[i];
                if (cmd.load)
                begin
                    if (i == 0)
                    begin
                        if (gt[i])
                        begin
                            cell_next[i] = new_entry;
                        end
                        valid_next[i] = 1'b1;
                    end
                    else
                    begin
                        if (gt[i])
                        begin
                            cell_next[i] = gt[(i == 0) ? 0 : i - 1]
                                ? cell_reg[(i == 0) ? 0 : i - 1] : new_entry;
                        end
                        valid_next[i] = valid_reg[i] | valid_reg[(i == 0) ? 0 : i - 1];
                    end
                end
                else if (cmd.emit)
                begin
                    if (i == ENTRIES - 1)
                    begin
                        valid_next[i] = 1'b0;
                    end
                    else
                    begin
                        cell_next[i]  = cell_reg[(i == ENTRIES - 1) ? i : i + 1];
                        valid_next[i] = valid_reg[(i == ENTRIES - 1) ? i : i + 1];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.out_type       <= cell_reg[0].item_type;
            out_reg.out_amount     <= cell_reg[0].amount;
            out_reg.out_name_index <= cell_reg[0].name_index;
            out_reg.out_last       <= cmd.emit_last;
        end
    end

    assign status.full     = valid_reg[ENTRIES-1];
    assign status.one_left = !valid_reg[1];
    assign out_data        = out_reg;

endmodule

/* sv/keyed_slot_sorter.sv */
// ============================================================================
// Keyed slot sorter
// Loads slot entries and emits them in ascending rank and type order.
// ============================================================================
// Entries load at one per clock while busy is low; each is placed in key order
// by an insertion chain in the same cycle it is taken. The entry marked last
// raises busy, which stays high while the stored entries are drained from the
// head of the chain one per clock; each result is copied to an output register
// as it leaves the head, so the results follow one another with no gaps.
// Results are strobed by out_valid for one cycle each and cannot be held off.
// Entries beyond the store depth are dropped, but their last mark still
// starts the output. Registers should be written only while the block is idle.
`timescale 1ns / 1ps

module keyed_slot_sorter
    import kss_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  in_item_t    in_item,
    output logic        out_valid,
    output out_item_t   out_item
);

    logic [1:0] sort_mode_reg;
    logic [7:0] empty_type_reg;
    logic       cfg_write;
    cfg_t       cfg;
    cmd_t       cmd;
    status_t    status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_mode_reg  <= MODE_BATTLE;
            empty_type_reg <= EMPTY_TYPE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_SORT_MODE:  sort_mode_reg  <= pwdata[1:0];
                REG_EMPTY_TYPE: empty_type_reg <= pwdata[7:0];
                default:        sort_mode_reg  <= sort_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SORT_MODE:  prdata = {30'd0, sort_mode_reg};
            REG_EMPTY_TYPE: prdata = {24'd0, empty_type_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.sort_mode  = sort_mode_reg;
    assign cfg.empty_type = empty_type_reg;

    kss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .in_last   (in_item.is_last),
        .status    (status),
        .busy      (busy),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    kss_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_item)
    );

endmodule

/* sv/kss_checker.sv */
// ============================================================================
// Keyed slot sorter checker
// Port-level checks on the sorter's command and result timing.
// ============================================================================
`timescale 1ns / 1ps
`include "keyed_slot_sorter_macros.svh"

module kss_checker
    import kss_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input in_item_t  in_item,
    input logic      out_valid,
    input out_item_t out_item
);

    `KSS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> (!busy && !out_valid))
    `KSS_ASSERT(a_last_starts_drain, (start && !busy && in_item.is_last) |=> busy)
    `KSS_ASSERT(a_result_needs_drain, out_valid |-> $past(busy))
    `KSS_ASSERT(a_drain_ends_on_last, $fell(busy) |-> (out_valid && out_item.out_last))
    `KSS_ASSERT(a_gap_after_last, (out_valid && out_item.out_last) |=> !out_valid)

endmodule

bind keyed_slot_sorter kss_checker u_kss_checker (.*);
